@@ hw/rtl/hpa_pkg.sv @@
// shared constants, types and aqi segment tables for the hourly pm2.5 averager
// no dependencies
package hpa_pkg;

  localparam int SENSOR_COUNT_DEF = 16;
  localparam int MAX_WINDOW_DEF   = 4096;

  // configuration register indexes
  localparam logic [1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [1:0] REG_SPW        = 2'd2;

  localparam logic [15:0] LOW_LIMIT_RST  = 16'd80;
  localparam logic [15:0] HIGH_LIMIT_RST = 16'd8808;
  localparam logic [12:0] SPW_RST        = 13'd360;

  localparam logic [8:0] AQI_MAX = 9'd500;

  // aqi slope division by 2 * span done as a multiply by a rounded-up reciprocal,
  // exact while numerator * divisor stays below 2 ** AQI_RCP_SHIFT
  localparam int AQI_RCP_SHIFT = 37;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV_AVG,
    ST_AQI_MUL,
    ST_AQI_RCP,
    ST_FIN
  } state_t;

  // segment number from the averaged concentration
  function automatic logic [2:0] aqi_seg(input logic [15:0] x);
    logic [2:0] s;
    s = 3'd0;
    if (x >= 16'd192)  s = 3'd1;
    if (x >= 16'd568)  s = 3'd2;
    if (x >= 16'd888)  s = 3'd3;
    if (x >= 16'd2408) s = 3'd4;
    if (x >= 16'd4008) s = 3'd5;
    if (x >= 16'd5608) s = 3'd6;
    return s;
  endfunction

  function automatic logic [15:0] seg_lo(input logic [2:0] s);
    logic [15:0] r;
    unique case (s)
      3'd0:    r = 16'd0;
      3'd1:    r = 16'd192;
      3'd2:    r = 16'd568;
      3'd3:    r = 16'd888;
      3'd4:    r = 16'd2408;
      3'd5:    r = 16'd4008;
      3'd6:    r = 16'd5608;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] seg_span(input logic [2:0] s);
    logic [11:0] r;
    unique case (s)
      3'd0:    r = 12'd192;
      3'd1:    r = 12'd376;
      3'd2:    r = 12'd320;
      3'd3:    r = 12'd1520;
      3'd4:    r = 12'd1600;
      3'd5:    r = 12'd1600;
      3'd6:    r = 12'd3200;
      default: r = 12'd192;
    endcase
    return r;
  endfunction

  // ceil(2 ** AQI_RCP_SHIFT / (2 * span)) per segment
  function automatic logic [28:0] seg_recip(input logic [2:0] s);
    logic [28:0] r;
    unique case (s)
      3'd0:    r = 29'(((64'd1 << AQI_RCP_SHIFT) + 64'd383) / 64'd384);
      3'd1:    r = 29'(((64'd1 << AQI_RCP_SHIFT) + 64'd751) / 64'd752);
      3'd2:    r = 29'(((64'd1 << AQI_RCP_SHIFT) + 64'd639) / 64'd640);
      3'd3:    r = 29'(((64'd1 << AQI_RCP_SHIFT) + 64'd3039) / 64'd3040);
      3'd4:    r = 29'(((64'd1 << AQI_RCP_SHIFT) + 64'd3199) / 64'd3200);
      3'd5:    r = 29'(((64'd1 << AQI_RCP_SHIFT) + 64'd3199) / 64'd3200);
      3'd6:    r = 29'(((64'd1 << AQI_RCP_SHIFT) + 64'd6399) / 64'd6400);
      default: r = 29'(((64'd1 << AQI_RCP_SHIFT) + 64'd383) / 64'd384);
    endcase
    return r;
  endfunction

  function automatic logic [8:0] seg_base(input logic [2:0] s);
    logic [8:0] r;
    unique case (s)
      3'd0:    r = 9'd0;
      3'd1:    r = 9'd50;
      3'd2:    r = 9'd100;
      3'd3:    r = 9'd150;
      3'd4:    r = 9'd200;
      3'd5:    r = 9'd300;
      3'd6:    r = 9'd400;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] seg_rise(input logic [2:0] s);
    logic [6:0] r;
    unique case (s)
      3'd4, 3'd5, 3'd6: r = 7'd100;
      default:          r = 7'd50;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/hpa_div.sv @@
// restoring divider, one quotient bit per cycle, used for the window mean
// no package dependencies
module hpa_div #(
  parameter int DVD_W = 29,
  parameter int DVR_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVR_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVR_W-1:0] rem;
  logic [DVR_W-1:0] dvr;
  logic [DVD_W-1:0] quo;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVR_W:0]   shifted;
  logic             ge;

  assign shifted  = {rem, quo[DVD_W-1]};
  assign ge       = shifted >= {1'b0, dvr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? DVR_W'(shifted - {1'b0, dvr}) : shifted[DVR_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

@@ hw/rtl/hourly_pm25_average_aqi_core.sv @@
// per-sensor hourly pm2.5 mean and aqi, sensor state in one memory; uses hpa_pkg, hpa_div
// a sample that leaves its window open holds the input through its accept and update steps
// a closing sample passes update, bit-serial mean division, aqi multiply, reciprocal scaling
// and handover to its result transfer; an empty window goes from update straight to handover
// one sample in flight; the next is accepted while a result waits in the output register
// reset: synchronous rst clears control, registers go to defaults, sensor entries read zero
module hourly_pm25_average_aqi_core #(
  parameter int SENSOR_COUNT = hpa_pkg::SENSOR_COUNT_DEF,
  parameter int MAX_WINDOW   = hpa_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // sensor_index[3:0], sample_value[19:4], zero pad
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sensor_number[3:0], average_value[19:4],
                                 // aqi_value[28:20], category[31:29]
  output logic        m_tuser,   // no_valid_samples
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = CNT_W + 16;
  localparam int DVD_W = SUM_W + 1;
  localparam int DVR_W = (CNT_W > 13) ? CNT_W : 13;
  localparam int ENT_W = SUM_W + 2 * CNT_W;

  // configuration
  logic [15:0] low_limit;
  logic [15:0] high_limit;
  logic [12:0] spw;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= hpa_pkg::LOW_LIMIT_RST;
      high_limit <= hpa_pkg::HIGH_LIMIT_RST;
      spw        <= hpa_pkg::SPW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpa_pkg::REG_LOW_LIMIT:  low_limit  <= cfg_data;
        hpa_pkg::REG_HIGH_LIMIT: high_limit <= cfg_data;
        hpa_pkg::REG_SPW:        spw        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // effective window length: zero acts as one, clipped to the largest window
  logic [CNT_W-1:0] w_eff;
  always_comb begin
    if (spw == 13'd0) begin
      w_eff = CNT_W'(1);
    end else if (32'(spw) > MAX_WINDOW) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(spw);
    end
  end

  hpa_pkg::state_t state, state_next;

  logic        in_xfer;
  logic        in_range;
  logic [AW-1:0] addr;
  assign in_xfer  = s_tvalid && s_tready;
  assign in_range = 32'(s_tdata[3:0]) < SENSOR_COUNT;
  assign addr     = AW'(s_tdata[3:0]);

  // captured sample
  logic [3:0]    sidx;
  logic [AW-1:0] addr_q;
  logic [15:0]   sval;

  // sensor memory: {position, valid count, sum}, registered read
  logic [ENT_W-1:0] mem [SENSOR_COUNT];
  logic [ENT_W-1:0] rd_data;
  logic             ent_vld [SENSOR_COUNT];
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= mem[addr];
      sidx    <= s_tdata[3:0];
      addr_q  <= addr;
      sval    <= s_tdata[19:4];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSOR_COUNT; i++) ent_vld[i] <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      if (in_xfer) rd_vld <= ent_vld[addr];
      if (state == hpa_pkg::ST_UPD) ent_vld[addr_q] <= 1'b1;
    end
  end

  // read-modify-write of the selected entry
  logic [ENT_W-1:0] ent;
  logic [SUM_W-1:0] sum_cur, sum_n;
  logic [CNT_W-1:0] cnt_cur, cnt_n, pos_cur;
  logic [CNT_W:0]   pos_inc;
  logic             hit;
  logic             close;
  logic [ENT_W-1:0] wr_data;

  always_comb begin
    ent     = rd_vld ? rd_data : '0;
    sum_cur = ent[SUM_W-1:0];
    cnt_cur = ent[SUM_W +: CNT_W];
    pos_cur = ent[SUM_W + CNT_W +: CNT_W];
    hit     = (sval >= low_limit) && (sval <= high_limit);
    sum_n   = hit ? sum_cur + SUM_W'(sval) : sum_cur;
    cnt_n   = hit ? cnt_cur + CNT_W'(1) : cnt_cur;
    pos_inc = {1'b0, pos_cur} + (CNT_W + 1)'(1);
    close   = pos_inc >= {1'b0, w_eff};
    // a closing window clears the entry
    wr_data = close ? '0 : {pos_inc[CNT_W-1:0], cnt_n, sum_n};
  end

  always_ff @(posedge clk) begin
    if (state == hpa_pkg::ST_UPD) mem[addr_q] <= wr_data;
  end

  // mean divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVR_W-1:0] div_dvr;
  logic [DVD_W-1:0] div_q;
  logic             div_done;

  hpa_div #(.DVD_W(DVD_W), .DVR_W(DVR_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvr),
    .quotient (div_q),
    .done     (div_done)
  );

  // result working registers
  logic [15:0] avg;
  logic [2:0]  seg;
  logic [8:0]  aqi;
  logic        none;
  logic        res_load;
  logic [23:0] aqi_num;

  // aqi slope numerator: 2 * rise * (x - lo) + span, divided by 2 * span
  // through the segment reciprocal, then the segment base added
  logic [15:0] diff;
  logic [23:0] prod;
  logic [52:0] aqi_scaled;
  logic [16:0] aqi_sum;
  assign diff       = avg - hpa_pkg::seg_lo(seg);
  assign prod       = {1'b0, hpa_pkg::seg_rise(seg), 1'b0} * {8'd0, diff};
  assign aqi_scaled = aqi_num * hpa_pkg::seg_recip(seg);
  assign aqi_sum    = 17'(aqi_scaled[52:hpa_pkg::AQI_RCP_SHIFT])
                    + 17'(hpa_pkg::seg_base(seg));

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvd    = DVD_W'(sum_n) + DVD_W'(cnt_n >> 1);
    div_dvr    = DVR_W'(cnt_n);
    res_load   = 1'b0;
    unique case (state)
      hpa_pkg::ST_IDLE: begin
        if (in_xfer && in_range) state_next = hpa_pkg::ST_UPD;
      end
      hpa_pkg::ST_UPD: begin
        if (!close) begin
          state_next = hpa_pkg::ST_IDLE;
        end else if (cnt_n != '0) begin
          div_start  = 1'b1;
          state_next = hpa_pkg::ST_DIV_AVG;
        end else begin
          state_next = hpa_pkg::ST_FIN;
        end
      end
      hpa_pkg::ST_DIV_AVG: begin
        if (div_done) state_next = hpa_pkg::ST_AQI_MUL;
      end
      hpa_pkg::ST_AQI_MUL: begin
        state_next = hpa_pkg::ST_AQI_RCP;
      end
      hpa_pkg::ST_AQI_RCP: begin
        state_next = hpa_pkg::ST_FIN;
      end
      hpa_pkg::ST_FIN: begin
        // hand over once the output register is free
        if (!m_tvalid || m_tready) begin
          res_load   = 1'b1;
          state_next = hpa_pkg::ST_IDLE;
        end
      end
      default: state_next = hpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      hpa_pkg::ST_UPD: begin
        // empty window result unless a division follows
        avg  <= '0;
        seg  <= '0;
        aqi  <= '0;
        none <= 1'b1;
      end
      hpa_pkg::ST_DIV_AVG: begin
        if (div_done) begin
          avg  <= div_q[15:0];
          seg  <= hpa_pkg::aqi_seg(div_q[15:0]);
          none <= 1'b0;
        end
      end
      hpa_pkg::ST_AQI_MUL: begin
        aqi_num <= prod + 24'(hpa_pkg::seg_span(seg));
      end
      hpa_pkg::ST_AQI_RCP: begin
        aqi <= (aqi_sum > 17'(hpa_pkg::AQI_MAX)) ? hpa_pkg::AQI_MAX : aqi_sum[8:0];
      end
      default: ;
    endcase
  end

  assign s_tready = (state == hpa_pkg::ST_IDLE);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {seg, aqi, avg, sidx};
      m_tuser <= none;
    end
  end

endmodule

@@ hw/rtl/hpa_checker.sv @@
// port-level checks for the hourly pm2.5 averager, bound to the top level
// depends on hourly_pm25_average_aqi_core ports only
module hpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an empty window reports zero mean, aqi and category
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[31:4] == 28'd0)
    else $error("empty window with nonzero result");

  a_aqi_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[28:20] <= 9'd500 && m_tdata[31:29] <= 3'd6)
    else $error("aqi or category out of range");

  // one sample in work at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sample taken while previous still in work");

endmodule

bind hourly_pm25_average_aqi_core hpa_checker u_hpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
